FILE: rtl/core/llzmd_pkg.sv
// Shared types, constants and the sine function for the lidar lane-zone minimum block.
`timescale 1ns / 1ps
`default_nettype none

package llzmd_pkg;

    localparam int unsigned APB_AW = 5;

    localparam logic [16:0] EMPTY_MM = 17'd99000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    typedef enum logic [2:0] {
        REG_LANE_WIDTH  = 3'd0,
        REG_CHECK_DIST  = 3'd1,
        REG_MIN_RANGE   = 3'd2,
        REG_ANGLE_START = 3'd3,
        REG_ANGLE_STEP  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] range_mm;
        logic        range_valid;
        logic        last_beam;
    } beam_t;

    typedef struct packed {
        logic [16:0] front_min_mm;
        logic [16:0] left_min_mm;
        logic [16:0] right_min_mm;
    } result_t;

    // Q1.15 sine of a binary angle, quarter-wave Taylor series in Q30.
    // Evaluated at elaboration only, to fill the sine ROM.
    function automatic logic signed [15:0] sine_of(input logic [31:0] a);
        logic [1:0]      quad;
        longint unsigned f;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned prod;
        longint          sum;
        longint unsigned mag;
        quad = a[31:30];
        f    = {34'd0, a[29:0]};
        if (quad[0])
        begin
            f = ONE_Q30 - f;
        end
        x    = (f * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 6; n++)
        begin
            prod = (term * x2) >> 30;
            case (n)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                default: term = prod / 64'd156;
            endcase
            if (n % 2 == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > longint'(ONE_Q30))
        begin
            sum = longint'(ONE_Q30);
        end
        mag = (longint'(sum) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
        if (quad[1])
        begin
            return -$signed(mag[15:0]);
        end
        return $signed(mag[15:0]);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/llzmd_sine_rom.sv
// Sine ROM with two registered read ports: sine and cosine of one binary angle.
`timescale 1ns / 1ps
`default_nettype none

module llzmd_sine_rom
    import llzmd_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
)
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [31:0]        angle,
    output logic signed [15:0]      sin_val,
    output logic signed [15:0]      cos_val
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned PW = 32 + AW;

    typedef logic signed [15:0] sine_rom_t [DEPTH];

    function automatic sine_rom_t build_rom();
        sine_rom_t       t;
        longint unsigned ang;
        for (int k = 0; k < int'(DEPTH); k++)
        begin
            ang  = (longint'(k) << 32) / DEPTH;
            t[k] = sine_of(ang[31:0]);
        end
        return t;
    endfunction

    localparam sine_rom_t SINE_ROM = build_rom();

    logic [31:0]    cos_angle;
    logic [PW-1:0]  sin_prod;
    logic [PW-1:0]  cos_prod;
    logic [AW-1:0]  sin_idx;
    logic [AW-1:0]  cos_idx;
    logic signed [15:0] sin_reg;
    logic signed [15:0] cos_reg;

    // index = floor(angle * DEPTH / 2^32)
    assign cos_angle = angle + QUARTER_TURN;
    assign sin_prod  = {{AW{1'b0}}, angle} * PW'(DEPTH);
    assign cos_prod  = {{AW{1'b0}}, cos_angle} * PW'(DEPTH);
    assign sin_idx   = sin_prod[PW-1:32];
    assign cos_idx   = cos_prod[PW-1:32];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= SINE_ROM[sin_idx];
            cos_reg <= SINE_ROM[cos_idx];
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

`default_nettype wire

FILE: rtl/core/lidar_lane_zone_min_distance.sv
// Top level: lidar beam to lane-zone minimum forward distance, per scan.
//
//  channel  | dir | handshake                        | payload
//  ---------+-----+----------------------------------+------------------------
//  beam     | in  | beam_valid / beam_ready          | beam_t (range, valid, last)
//  result   | out | result_valid / result_ready      | result_t (three minima)
//  apb      | in  | psel / penable / pwrite / pready | paddr, pwdata, prdata
//
// One beam per cycle unless a held result stalls a last beam. Three register stages: ROM
// read at the beam beat, the two range-by-trig multiplies, lane compare and min update.
// A result is registered from the min stage when its last beam is consumed there.
// A held result stalls a later last beam at the min stage and the beams queued behind it.
// Reset clears the minima to 99000 and both the beam angle and angle_start to zero.
`timescale 1ns / 1ps
`default_nettype none

module lidar_lane_zone_min_distance
    import llzmd_pkg::*;
#(
    parameter int unsigned SINE_TABLE_DEPTH = 1024
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               beam_valid,
    output logic                    beam_ready,
    input  wire beam_t              beam,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output result_t                 result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // configuration
    logic [11:0]        lane_width_reg;
    logic [15:0]        check_dist_reg;
    logic [15:0]        min_range_reg;
    logic signed [31:0] angle_start_reg;
    logic signed [31:0] angle_step_reg;
    logic               cfg_wr;
    cfg_reg_t           cfg_sel;

    logic [31:0]        beam_angle_reg;
    logic [31:0]        beam_angle_next;

    // stage 1: ROM output and beam flags
    logic               s1_valid_reg;
    logic               s1_keep_reg;
    logic               s1_last_reg;
    logic [15:0]        s1_range_reg;
    logic signed [15:0] sin_val;
    logic signed [15:0] cos_val;

    // stage 2: forward and lateral coordinates
    logic               s2_valid_reg;
    logic               s2_keep_reg;
    logic               s2_last_reg;
    logic signed [17:0] s2_x_reg;
    logic signed [17:0] s2_y_reg;
    logic signed [32:0] x_prod;
    logic signed [32:0] y_prod;

    // stage 3: minima and result
    logic [16:0]        front_min_reg;
    logic [16:0]        left_min_reg;
    logic [16:0]        right_min_reg;
    logic [16:0]        front_min_next;
    logic [16:0]        left_min_next;
    logic [16:0]        right_min_next;
    logic               out_valid_reg;
    result_t            out_data_reg;

    logic               beam_fire;
    logic               stall2;
    logic               s2_load;
    logic               consume;
    logic               keep_now;

    logic signed [19:0] y2;
    logic signed [19:0] w1;
    logic signed [19:0] w3;
    logic [16:0]        ux;
    logic               in_center;
    logic               in_left;
    logic               in_right;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (cfg_sel)
            REG_LANE_WIDTH:  prdata = {20'd0, lane_width_reg};
            REG_CHECK_DIST:  prdata = {16'd0, check_dist_reg};
            REG_MIN_RANGE:   prdata = {16'd0, min_range_reg};
            REG_ANGLE_START: prdata = angle_start_reg;
            REG_ANGLE_STEP:  prdata = angle_step_reg;
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_width_reg  <= 12'd600;
            check_dist_reg  <= 16'd2000;
            min_range_reg   <= 16'd100;
            angle_start_reg <= 32'sd0;
            angle_step_reg  <= 32'sd0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_LANE_WIDTH:  lane_width_reg  <= pwdata[11:0];
                REG_CHECK_DIST:  check_dist_reg  <= pwdata[15:0];
                REG_MIN_RANGE:   min_range_reg   <= pwdata[15:0];
                REG_ANGLE_START: angle_start_reg <= pwdata;
                REG_ANGLE_STEP:  angle_step_reg  <= pwdata;
                default:         ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    assign stall2     = s2_valid_reg && s2_last_reg && out_valid_reg && !result_ready;
    assign s2_load    = !s2_valid_reg || !stall2;
    assign consume    = s2_valid_reg && !stall2;
    assign beam_ready = !s1_valid_reg || s2_load;
    assign beam_fire  = beam_valid && beam_ready;

    // ---------------- beam angle ----------------
    always_comb
    begin
        beam_angle_next = beam_angle_reg;
        if (cfg_wr && cfg_sel == REG_ANGLE_START)
        begin
            beam_angle_next = pwdata;
        end
        else if (beam_fire)
        begin
            if (beam.last_beam)
            begin
                beam_angle_next = angle_start_reg;
            end
            else
            begin
                beam_angle_next = beam_angle_reg + angle_step_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_angle_reg <= 32'd0;
        end
        else
        begin
            beam_angle_reg <= beam_angle_next;
        end
    end

    // ---------------- stage 1 ----------------
    assign keep_now = beam.range_valid && (beam.range_mm <= check_dist_reg)
                      && (beam.range_mm >= min_range_reg);

    llzmd_sine_rom #(
        .DEPTH   (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .clk     (clk),
        .en      (beam_fire),
        .angle   (beam_angle_reg),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (beam_ready)
        begin
            s1_valid_reg <= beam_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beam_fire)
        begin
            s1_keep_reg  <= keep_now;
            s1_last_reg  <= beam.last_beam;
            s1_range_reg <= beam.range_mm;
        end
    end

    // ---------------- stage 2 ----------------
    // Q1.15 products; taking bits [32:15] is a floor shift
    assign x_prod = $signed({1'b0, s1_range_reg}) * cos_val;
    assign y_prod = $signed({1'b0, s1_range_reg}) * sin_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            s2_keep_reg <= s1_keep_reg;
            s2_last_reg <= s1_last_reg;
            s2_x_reg    <= x_prod[32:15];
            s2_y_reg    <= y_prod[32:15];
        end
    end

    // ---------------- stage 3 ----------------
    // lane tests on 2y against w and 3w, all strict
    assign y2 = {{1{s2_y_reg[17]}}, s2_y_reg, 1'b0};
    assign w1 = $signed({8'd0, lane_width_reg});
    assign w3 = $signed({7'd0, lane_width_reg, 1'b0}) + w1;
    assign ux = s2_x_reg[16:0];

    assign in_center = (y2 < w1) && (y2 > -w1);
    assign in_left   = (y2 > w1) && (y2 < w3);
    assign in_right  = (y2 < -w1) && (y2 > -w3);

    always_comb
    begin
        front_min_next = front_min_reg;
        left_min_next  = left_min_reg;
        right_min_next = right_min_reg;
        if (s2_keep_reg && !s2_x_reg[17])
        begin
            if (in_center)
            begin
                if (ux < front_min_reg)
                begin
                    front_min_next = ux;
                end
            end
            else if (in_left)
            begin
                if (ux < left_min_reg)
                begin
                    left_min_next = ux;
                end
            end
            else if (in_right)
            begin
                if (ux < right_min_reg)
                begin
                    right_min_next = ux;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_min_reg <= EMPTY_MM;
            left_min_reg  <= EMPTY_MM;
            right_min_reg <= EMPTY_MM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (consume)
            begin
                if (s2_last_reg)
                begin
                    front_min_reg <= EMPTY_MM;
                    left_min_reg  <= EMPTY_MM;
                    right_min_reg <= EMPTY_MM;
                end
                else
                begin
                    front_min_reg <= front_min_next;
                    left_min_reg  <= left_min_next;
                    right_min_reg <= right_min_next;
                end
            end
            if (consume && s2_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && s2_last_reg)
        begin
            out_data_reg.front_min_mm <= front_min_next;
            out_data_reg.left_min_mm  <= left_min_next;
            out_data_reg.right_min_mm <= right_min_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

`ifndef NO_ASSERTIONS
    // a held result is never overwritten by the next scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ready) |-> !(consume && s2_last_reg))
        else $error("result overwritten while held");

    // end of scan leaves all three minima empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (consume && s2_last_reg) |=>
            (front_min_reg == EMPTY_MM) && (left_min_reg == EMPTY_MM)
            && (right_min_reg == EMPTY_MM))
        else $error("minima not cleared after last beam");

    // last beam reloads the angle with angle_start
    assert property (@(posedge clk) disable iff (!rst_n)
        (beam_fire && beam.last_beam && !(cfg_wr && cfg_sel == REG_ANGLE_START))
            |=> beam_angle_reg == $past(angle_start_reg))
        else $error("beam angle not reloaded at end of scan");

    // minima never exceed the empty marker
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.front_min_mm <= EMPTY_MM)
            && (result.left_min_mm <= EMPTY_MM) && (result.right_min_mm <= EMPTY_MM))
        else $error("result minimum above empty marker");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_lidar_lane_zone_min_distance.sv
// Self-checking testbench for the lidar lane-zone minimum distance block.
`timescale 1ns / 1ps

module tb_lidar_lane_zone_min_distance;
    import llzmd_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
    localparam logic [16:0] NO_HIT_MM = 17'd99000;
    localparam logic [31:0] QUARTER = 32'h4000_0000;
    localparam logic [2:0] UNUSED_REG = 3'd5;
    localparam int NUM_PHASES = 9;
    localparam int BEATS_PER_PHASE = 114;
    localparam int DRAIN_CYCLES = 8;

    // Tracks lane minima per scan and holds the minima each scan should report.
    class lane_min_scoreboard;
        int          sin_rom[TABLE_DEPTH];
        logic [11:0] lane_w;
        logic [15:0] max_range;
        logic [15:0] min_range;
        logic [31:0] start_angle;
        logic [31:0] step_angle;
        logic [31:0] angle;
        logic [16:0] front_min;
        logic [16:0] left_min;
        logic [16:0] right_min;
        result_t     expected_minima[$];
        int          errors;
        int          results_seen;

        function new();
            for (int k = 0; k < TABLE_DEPTH; k++)
            begin
                sin_rom[k] = sine_q15(32'((longint'(k) << 32) / TABLE_DEPTH));
            end
            lane_w       = 12'd600;
            max_range    = 16'd2000;
            min_range    = 16'd100;
            start_angle  = '0;
            step_angle   = '0;
            angle        = '0;
            front_min    = NO_HIT_MM;
            left_min     = NO_HIT_MM;
            right_min    = NO_HIT_MM;
            errors       = 0;
            results_seen = 0;
        endfunction

        // Quarter-wave Taylor series in Q30, rounded to Q1.15.
        function int sine_q15(logic [31:0] a);
            longint unsigned frac;
            longint unsigned u;
            longint unsigned u2;
            longint unsigned t;
            longint unsigned m;
            longint          acc;
            frac = longint'(a[29:0]);
            if (a[30])
            begin
                frac = Q30_ONE - frac;
            end
            u   = (frac * Q30_HALF_PI) >> 30;
            u2  = (u * u) >> 30;
            t   = u;
            acc = longint'(u);
            for (int n = 1; n <= 6; n++)
            begin
                t = ((t * u2) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                begin
                    acc = acc - longint'(t);
                end
                else
                begin
                    acc = acc + longint'(t);
                end
            end
            if (acc < 0)
            begin
                acc = 0;
            end
            if (acc > longint'(Q30_ONE))
            begin
                acc = longint'(Q30_ONE);
            end
            m = ($unsigned(acc) * 64'd32767 + (Q30_ONE >> 1)) >> 30;
            return a[31] ? -int'(m) : int'(m);
        endfunction

        function longint rom_at(logic [31:0] a);
            return longint'(sin_rom[(longint'(a) * TABLE_DEPTH) >> 32]);
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_LANE_WIDTH:  lane_w = val[11:0];
                REG_CHECK_DIST:  max_range = val[15:0];
                REG_MIN_RANGE:   min_range = val[15:0];
                REG_ANGLE_START:
                begin
                    start_angle = val;
                    angle       = val;
                end
                REG_ANGLE_STEP:  step_angle = val;
                default:         ;
            endcase
        endfunction

        function void note_beam(beam_t b);
            longint  cosv;
            longint  sinv;
            longint  fwd;
            longint  lat2;
            longint  w;
            result_t r;
            if (b.range_valid && b.range_mm <= max_range && b.range_mm >= min_range)
            begin
                cosv = rom_at(angle + QUARTER);
                sinv = rom_at(angle);
                fwd  = (longint'(b.range_mm) * cosv) >>> 15;
                lat2 = 2 * ((longint'(b.range_mm) * sinv) >>> 15);
                w    = longint'(lane_w);
                if (fwd >= 0)
                begin
                    if ((lat2 < 0 ? -lat2 : lat2) < w)
                    begin
                        if (fwd < longint'(front_min))
                        begin
                            front_min = 17'(fwd);
                        end
                    end
                    else if (lat2 > w && lat2 < 3 * w)
                    begin
                        if (fwd < longint'(left_min))
                        begin
                            left_min = 17'(fwd);
                        end
                    end
                    else if (lat2 < -w && lat2 > -3 * w)
                    begin
                        if (fwd < longint'(right_min))
                        begin
                            right_min = 17'(fwd);
                        end
                    end
                end
            end
            angle = angle + step_angle;
            if (b.last_beam)
            begin
                r.front_min_mm = front_min;
                r.left_min_mm  = left_min;
                r.right_min_mm = right_min;
                expected_minima = {expected_minima, r};
                front_min = NO_HIT_MM;
                left_min  = NO_HIT_MM;
                right_min = NO_HIT_MM;
                angle     = start_angle;
            end
        endfunction

        function void compare_lane(string lane, logic [16:0] want, logic [16:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s minimum mismatch: expected %0d, actual %0d",
                         $time, lane, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_minima.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat: expected none, actual %0d/%0d/%0d",
                         $time, got.front_min_mm, got.left_min_mm, got.right_min_mm);
                return;
            end
            want = expected_minima.pop_front();
            results_seen++;
            compare_lane("front", want.front_min_mm, got.front_min_mm);
            compare_lane("left", want.left_min_mm, got.left_min_mm);
            compare_lane("right", want.right_min_mm, got.right_min_mm);
        endfunction

        function int pending();
            return expected_minima.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              beam_valid = 1'b0;
    logic              beam_ready;
    beam_t             beam = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    result_t           result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    lane_min_scoreboard sb = new();
    int tx_idle_pct = 36;
    int rx_idle_pct = 54;
    int beats_sent = 0;

    lidar_lane_zone_min_distance #(
        .SINE_TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .beam_valid   (beam_valid),
        .beam_ready   (beam_ready),
        .beam         (beam),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: sample the pre-edge handshake, then pick next ready.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            sb.check_result(result);
        end
        result_ready <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_beam(input beam_t b);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            beam_valid <= 1'b0;
            @(posedge clk);
        end
        beam_valid <= 1'b1;
        beam       <= b;
        do
        begin
            @(posedge clk);
        end
        while (!beam_ready);
        sb.note_beam(b);
        beats_sent++;
    endtask

    task automatic beam_item(input logic [15:0] rng, input logic vld, input logic last);
        beam_t b;
        b.range_mm    = rng;
        b.range_valid = vld;
        b.last_beam   = last;
        send_beam(b);
    endtask

    // Let the pipeline empty before touching registers; beams without a
    // result may still be in flight when the queue runs dry.
    task automatic wait_drained();
        beam_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_beams(input int count);
        int    remaining;
        int    scan_len;
        int    roll;
        beam_t b;
        remaining = count;
        while (remaining > 0)
        begin
            scan_len = $urandom_range(1, 24);
            for (int k = 0; k < scan_len && remaining > 0; k++)
            begin
                roll          = $urandom_range(0, 99);
                b.range_valid = 1'b1;
                b.last_beam   = (k == scan_len - 1);
                if (roll < 80)
                begin
                    b.range_mm = 16'($urandom_range(sb.min_range, sb.max_range));
                end
                else if (roll < 90)
                begin
                    b.range_mm = 16'($urandom);
                end
                else
                begin
                    b.range_mm    = 16'($urandom);
                    b.range_valid = 1'b0;
                end
                // broken scans: stray or missing last marker
                if (roll >= 97)
                begin
                    b.last_beam = 1'($urandom_range(0, 1));
                end
                send_beam(b);
                remaining--;
            end
        end
    endtask

    task automatic program_phase(input int ph);
        logic [31:0] step;
        step = $urandom_range(0, 32'h1000_0000);
        if ($urandom_range(0, 1))
        begin
            step = -step;
        end
        case (ph)
            0:
            begin
                reg_write(REG_LANE_WIDTH, 32'd4095);
                reg_write(REG_CHECK_DIST, 32'd65535);
                reg_write(REG_MIN_RANGE, 32'd0);
                reg_write(REG_ANGLE_START, 32'h8000_0000);
                reg_write(REG_ANGLE_STEP, 32'h7FFF_FFFF);
            end
            1:
            begin
                reg_write(REG_LANE_WIDTH, 32'd1);
                reg_write(REG_CHECK_DIST, 32'd1);
                reg_write(REG_MIN_RANGE, 32'd0);
                reg_write(REG_ANGLE_START, 32'h7FFF_FFFF);
                reg_write(REG_ANGLE_STEP, 32'h8000_0000);
            end
            2:
            begin
                reg_write(REG_LANE_WIDTH, 32'd1000);
                reg_write(REG_CHECK_DIST, 32'd65535);
                reg_write(REG_MIN_RANGE, 32'd65535);
                reg_write(REG_ANGLE_START, $urandom);
                reg_write(REG_ANGLE_STEP, step);
            end
            default:
            begin
                reg_write(REG_LANE_WIDTH, $urandom_range(1, 4000));
                reg_write(REG_CHECK_DIST, $urandom_range(1000, 65535));
                reg_write(REG_MIN_RANGE, $urandom_range(0, 500));
                reg_write(REG_ANGLE_START, $urandom);
                reg_write(REG_ANGLE_STEP, step);
            end
        endcase
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: every beam at angle zero, so only the center lane
        beam_item(16'd0, 1'b0, 1'b1);
        beam_item(16'd100, 1'b1, 1'b0);
        beam_item(16'd99, 1'b1, 1'b0);
        beam_item(16'd2000, 1'b1, 1'b0);
        beam_item(16'd2001, 1'b1, 1'b0);
        beam_item(16'd0, 1'b1, 1'b0);
        beam_item(16'hFFFF, 1'b0, 1'b0);
        beam_item(16'd500, 1'b0, 1'b1);
        wait_drained();

        // sweep -90 to +112.5 deg, wrapping through zero; hits all three lanes
        reg_write(UNUSED_REG, 32'hFFFF_FFFF);
        reg_write(REG_MIN_RANGE, 32'd0);
        reg_write(REG_CHECK_DIST, 32'd65535);
        reg_write(REG_ANGLE_START, 32'hC000_0000);
        reg_write(REG_ANGLE_STEP, 32'h1000_0000);
        for (int k = 0; k < 10; k++)
        begin
            beam_item((k == 4) ? 16'hFFFF : 16'd1000, 1'b1, k == 9);
        end
        wait_drained();

        reg_write(REG_LANE_WIDTH, 32'd0);
        beam_item(16'd1000, 1'b1, 1'b0);
        beam_item(16'd0, 1'b1, 1'b0);
        beam_item(16'd300, 1'b1, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            case (ph / 3)
                0:
                begin
                    tx_idle_pct = 36;
                    rx_idle_pct = 54;
                end
                1:
                begin
                    tx_idle_pct = 54;
                    rx_idle_pct = 36;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            program_phase(ph);
            random_beams(BEATS_PER_PHASE);
        end

        wait_drained();
        $display("Sent %0d beam beats over %0d register settings (zero, minimum and",
                 beats_sent, NUM_PHASES + 3);
        $display("maximum widths and ranges, wrapping angles); %0d scan results compared",
                 sb.results_seen);
        if (sb.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d scan results outstanding", sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: lidar_lane_zone_min_distance.f
rtl/core/llzmd_pkg.sv
rtl/core/llzmd_sine_rom.sv
rtl/core/lidar_lane_zone_min_distance.sv
tb/tb_lidar_lane_zone_min_distance.sv
